/* rtl/okl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_pkg: shared types and constants of the ordered key list engine
// Command and status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W    = 32;
    localparam int GRADE_W  = 10;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_BADPOS   = 3'd2,
        STS_DUP      = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_GET,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic [FPOS_W-1:0]          position;
        logic signed [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]         grade;
    } result_t;

endpackage

/* rtl/okl_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_store: entry memory of the ordered key list engine
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module okl_store #(
    parameter int DEPTH = okl_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [okl_pkg::KEY_W-1:0]   wr_key,
    input  logic [okl_pkg::GRADE_W-1:0]        wr_grade,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [okl_pkg::KEY_W-1:0]   rd_key,
    output logic [okl_pkg::GRADE_W-1:0]        rd_grade
);
    import okl_pkg::*;

    logic [KEY_W+GRADE_W-1:0] mem [DEPTH];
    logic [KEY_W+GRADE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_grade};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[KEY_W+GRADE_W-1:GRADE_W];
    assign rd_grade = rd_data_reg[GRADE_W-1:0];

endmodule

/* rtl/ordered_key_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_list_engine_core: packed ordered list of keyed entries
// Insert, delete, find-by-key and get-at-position over one entry memory.
//
// Input channel (in_valid/in_ready) carries cmd, position, entry_key and
// entry_grade; output channel (out_valid/out_ready) returns one transaction
// per command: status, found_position, found_key, found_grade, entry_count.
// One command is worked at a time; in_ready is high only when the sequencer
// is idle. All work goes through the one entry memory, one access a cycle:
//   key scan (insert, find): one read per entry visited
//   insert shift: a read and a write per entry moved, then the new entry
//   delete shift: a read and a write per entry moved
//   get: a single read; a rejected command goes straight to the result.
// Each command also passes through acceptance in the idle state and the done
// state, which hands the result to the output register.
// A finished result waits in the output register while the receiver stalls;
// the next command is taken meanwhile and its result is held until the
// output register frees up.
// Reset empties the list; memory contents are not cleared and are only read
// below the entry count.
// ----------------------------------------------------------------------------
module ordered_key_list_engine_core #(
    parameter int CAPACITY = okl_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [okl_pkg::CMD_W-1:0]            cmd,
    input  logic [okl_pkg::POS_W-1:0]            position,
    input  logic signed [okl_pkg::KEY_W-1:0]     entry_key,
    input  logic [okl_pkg::GRADE_W-1:0]          entry_grade,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [okl_pkg::STATUS_W-1:0]         status,
    output logic [okl_pkg::FPOS_W-1:0]           found_position,
    output logic signed [okl_pkg::KEY_W-1:0]     found_key,
    output logic [okl_pkg::GRADE_W-1:0]          found_grade,
    output logic [okl_pkg::COUNT_W-1:0]          entry_count
);
    import okl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic                     pend_reg, pend_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [GRADE_W-1:0]       grade_reg, grade_next;
    result_t                  res_reg, res_next;

    logic                     out_valid_reg;
    result_t                  out_res_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_load;

    logic                     wr_en, rd_en;
    logic [IDX_W-1:0]         wr_addr, rd_addr;
    logic signed [KEY_W-1:0]  wr_key, rd_key;
    logic [GRADE_W-1:0]       wr_grade, rd_grade;

    logic [CMP_W-1:0]         pos_x, cnt_x, cap_x;
    logic [CNT_W-1:0]         idx_prev;

    okl_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_grade (wr_grade),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_grade (rd_grade)
    );

    assign pos_x    = CMP_W'(position);
    assign cnt_x    = CMP_W'(count_reg);
    assign cap_x    = CMP_W'(CAPACITY);
    assign idx_prev = idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        pend_reg  <= pend_next;
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        grade_reg <= grade_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            out_res_reg   <= res_reg;
            out_count_reg <= COUNT_W'(count_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        grade_next = grade_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_key     = key_reg;
        wr_grade   = grade_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[IDX_W-1:0];
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(cmd);
                    key_next   = entry_key;
                    grade_next = entry_grade;
                    res_next   = '{status: STS_BADPOS, default: '0};
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    unique case (cmd_t'(cmd))
                        CMD_INSERT:
                        begin
                            if (cnt_x >= cap_x)
                            begin
                                res_next.status = STS_FULL;
                                state_next      = ST_DONE;
                            end
                            else if (pos_x > cap_x)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                // past the end becomes an append
                                pos_next   = (pos_x > cnt_x) ? count_reg : CNT_W'(position);
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(position);
                                pos_next   = CNT_W'(position);
                                state_next = ST_DEL_RD;
                            end
                        end
                        CMD_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_GET:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(position);
                                pos_next   = CNT_W'(position);
                                state_next = ST_GET;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // compare the entry read last cycle while reading the next one
                if (pend_reg && rd_key == key_reg)
                begin
                    if (cmd_reg == CMD_FIND)
                    begin
                        res_next = '{status: STS_OK, position: FPOS_W'(idx_prev),
                                     key: rd_key, grade: rd_grade};
                    end
                    else
                    begin
                        res_next = '{status: STS_DUP, default: '0};
                    end
                    state_next = ST_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    if (cmd_reg == CMD_FIND)
                    begin
                        res_next   = '{status: STS_NOTFOUND, default: '0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end

            ST_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res_next   = '{status: STS_OK, position: FPOS_W'(pos_reg), default: '0};
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_prev[IDX_W-1:0];
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_key     = rd_key;
                wr_grade   = rd_grade;
                idx_next   = idx_prev;
                state_next = ST_SHIFT_RD;
            end

            ST_DEL_RD:
            begin
                if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_next   = '{status: STS_OK, position: FPOS_W'(pos_reg), default: '0};
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(idx_reg + CNT_W'(1));
                    state_next = ST_DEL_WR;
                end
            end

            ST_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_key     = rd_key;
                wr_grade   = rd_grade;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_DEL_RD;
            end

            ST_GET:
            begin
                res_next = '{status: STS_OK, position: FPOS_W'(pos_reg),
                             key: rd_key, grade: rd_grade};
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign found_position = out_res_reg.position;
    assign found_key      = out_res_reg.key;
    assign found_grade    = out_res_reg.grade;
    assign entry_count    = out_count_reg;

endmodule
